/* rtl/ipd_http_chunked_deframer_defines.svh */
// assertion macros for the modem reply deframer
// used by the port checker; relies on clk and rst_n in the including scope
`ifndef IPD_HTTP_CHUNKED_DEFRAMER_DEFINES_SVH
`define IPD_HTTP_CHUNKED_DEFRAMER_DEFINES_SVH

// clocked property, off during reset
`define IPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// payload holds while a transfer is stalled
`define IPD_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
    `IPD_ASSERT(lbl, (vld && !rdy) |=> $stable(sig), msg)

`endif

/* rtl/ipd_pkg.sv */
// shared constants, types and character helpers for the modem reply deframer
// no dependencies
`default_nettype none

package ipd_pkg;

    localparam int PACKET_LEN_BITS = 16;
    localparam int CHUNK_LEN_BITS  = 32;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_0     = 8'd48;
    localparam logic [7:0] CH_9     = 8'd57;
    localparam logic [7:0] CH_UA    = 8'd65;
    localparam logic [7:0] CH_UF    = 8'd70;
    localparam logic [7:0] CH_LA    = 8'd97;
    localparam logic [7:0] CH_LF_HEX = 8'd102;

    localparam logic [2:0] MARK_LEN = 3'd5;
    localparam logic [2:0] END_LEN  = 3'd4;
    localparam logic [2:0] WORD_LEN = 3'd7;

    typedef enum logic [1:0] {
        PH_FIND = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } outer_phase_t;

    typedef enum logic {
        CHUNK_SIZE = 1'b0,
        CHUNK_DATA = 1'b1
    } chunk_phase_t;

    typedef struct packed {
        logic       valid;
        logic       restart;
        logic [7:0] data;
    } ipd_step_t;

    function automatic logic [7:0] mark_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = CH_PLUS;
            3'd1:    c = CH_I;
            3'd2:    c = CH_P;
            3'd3:    c = CH_D;
            default: c = CH_COMMA;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] end_char(input logic [2:0] idx);
        return idx[0] ? CH_LF : CH_CR;
    endfunction

    function automatic logic [7:0] word_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h63;
            3'd1:    c = 8'h68;
            3'd2:    c = 8'h75;
            3'd3:    c = 8'h6E;
            3'd4:    c = 8'h6B;
            3'd5:    c = 8'h65;
            default: c = 8'h64;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [3:0] v;
        priority if (b >= CH_0 && b <= CH_9)
            v = b[3:0];
        else if ((b >= CH_UA && b <= CH_UF) || (b >= CH_LA && b <= CH_LF_HEX))
            v = b[3:0] + 4'd9;
        else if (b[7])
            v = 4'd0;
        else if (b[7:4] == 4'd0)
            v = b[3:0];
        else
            v = 4'hF;
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/ipd_rx_if.sv */
// input channel: valid/ready handshake with action and raw byte
// no dependencies
`default_nettype none

interface ipd_rx_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] byte_in;

    modport source (output valid, output action, output byte_in, input ready);
    modport sink   (input valid, input action, input byte_in, output ready);
endinterface

`default_nettype wire

/* rtl/ipd_tx_if.sv */
// output channel: valid/ready handshake with one payload byte
// no dependencies
`default_nettype none

interface ipd_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

`default_nettype wire

/* rtl/ipd_outer.sv */
// outer framing layer: marker hunt, decimal length, packet byte gating
// depends on ipd_pkg
`default_nettype none

module ipd_outer #(
    parameter int PACKET_LEN_BITS = ipd_pkg::PACKET_LEN_BITS
) (
    input  wire                clk,
    input  wire                rst_n,
    input  ipd_pkg::ipd_step_t step,
    output logic               pass
);

    localparam int AW = PACKET_LEN_BITS + 4;

    ipd_pkg::outer_phase_t      phase_reg, phase_next;
    logic [2:0]                 match_reg, match_next;
    logic [PACKET_LEN_BITS-1:0] acc_reg, acc_next;
    logic                       stop_reg, stop_next;
    logic [PACKET_LEN_BITS-1:0] remain_reg, remain_next;

    logic [2:0]  idx;
    logic [AW-1:0] acc_x10;
    logic        is_digit;

    always_comb
    begin
        idx      = (match_reg >= ipd_pkg::MARK_LEN) ? 3'd0 : match_reg;
        is_digit = (step.data >= ipd_pkg::CH_0) && (step.data <= ipd_pkg::CH_9);
        acc_x10  = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                 + AW'(step.data[3:0]);

        phase_next  = phase_reg;
        match_next  = match_reg;
        acc_next    = acc_reg;
        stop_next   = stop_reg;
        remain_next = remain_reg;
        pass        = 1'b0;

        if (step.valid)
        begin
            if (step.restart)
            begin
                phase_next  = ipd_pkg::PH_FIND;
                match_next  = 3'd0;
                acc_next    = '0;
                stop_next   = 1'b0;
                remain_next = '0;
            end
            else
            begin
                unique case (phase_reg)
                    ipd_pkg::PH_LEN:
                    begin
                        if (step.data == ipd_pkg::CH_COLON)
                        begin
                            remain_next = acc_reg;
                            acc_next    = '0;
                            stop_next   = 1'b0;
                            phase_next  = ipd_pkg::PH_DATA;
                        end
                        else if (!stop_reg && is_digit)
                        begin
                            acc_next = (|acc_x10[AW-1:PACKET_LEN_BITS]) ? '1
                                     : acc_x10[PACKET_LEN_BITS-1:0];
                        end
                        else
                        begin
                            stop_next = 1'b1;
                        end
                    end
                    ipd_pkg::PH_DATA:
                    begin
                        if (remain_reg != '0)
                        begin
                            remain_next = remain_reg - 1'b1;
                            pass        = 1'b1;
                        end
                        else
                        begin
                            phase_next = ipd_pkg::PH_FIND;
                        end
                    end
                    default:
                    begin
                        phase_next = ipd_pkg::PH_FIND;
                        if (step.data == ipd_pkg::mark_char(idx))
                        begin
                            if (idx + 3'd1 == ipd_pkg::MARK_LEN)
                            begin
                                match_next = 3'd0;
                                phase_next = ipd_pkg::PH_LEN;
                            end
                            else
                            begin
                                match_next = idx + 3'd1;
                            end
                        end
                        else
                        begin
                            match_next = (step.data == ipd_pkg::CH_PLUS) ? 3'd1 : 3'd0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ipd_pkg::PH_FIND;
            match_reg  <= 3'd0;
            acc_reg    <= '0;
            stop_reg   <= 1'b0;
            remain_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            match_reg  <= match_next;
            acc_reg    <= acc_next;
            stop_reg   <= stop_next;
            remain_reg <= remain_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/ipd_body.sv */
// header skip and chunked body decoding for bytes inside a packet
// depends on ipd_pkg
`default_nettype none

module ipd_body #(
    parameter int CHUNK_LEN_BITS = ipd_pkg::CHUNK_LEN_BITS
) (
    input  wire                clk,
    input  wire                rst_n,
    input  ipd_pkg::ipd_step_t step,
    output logic               emit
);

    logic                      hdr_done_reg, hdr_done_next;
    logic [2:0]                end_match_reg, end_match_next;
    logic [2:0]                word_match_reg, word_match_next;
    logic                      chunked_reg, chunked_next;
    ipd_pkg::chunk_phase_t     cphase_reg, cphase_next;
    logic [CHUNK_LEN_BITS-1:0] cremain_reg, cremain_next;
    logic                      skip_reg, skip_next;

    logic [2:0] end_idx;

    always_comb
    begin
        end_idx = (end_match_reg >= ipd_pkg::END_LEN) ? 3'd0 : end_match_reg;

        hdr_done_next   = hdr_done_reg;
        end_match_next  = end_match_reg;
        word_match_next = word_match_reg;
        chunked_next    = chunked_reg;
        cphase_next     = cphase_reg;
        cremain_next    = cremain_reg;
        skip_next       = skip_reg;
        emit            = 1'b0;

        if (step.restart)
        begin
            hdr_done_next   = 1'b0;
            end_match_next  = 3'd0;
            word_match_next = 3'd0;
            chunked_next    = 1'b0;
            cphase_next     = ipd_pkg::CHUNK_SIZE;
            cremain_next    = '0;
            skip_next       = 1'b0;
        end
        else if (step.valid)
        begin
            if (!hdr_done_reg)
            begin
                if (word_match_reg < ipd_pkg::WORD_LEN)
                begin
                    if (step.data == ipd_pkg::word_char(word_match_reg))
                        word_match_next = word_match_reg + 3'd1;
                    else
                        word_match_next = (step.data == ipd_pkg::word_char(3'd0))
                                        ? 3'd1 : 3'd0;
                end
                if (step.data == ipd_pkg::end_char(end_idx))
                begin
                    if (end_idx + 3'd1 == ipd_pkg::END_LEN)
                    begin
                        end_match_next = 3'd0;
                        hdr_done_next  = 1'b1;
                        if (word_match_next == ipd_pkg::WORD_LEN)
                        begin
                            chunked_next = 1'b1;
                            cphase_next  = ipd_pkg::CHUNK_SIZE;
                            cremain_next = '0;
                            skip_next    = 1'b0;
                        end
                    end
                    else
                    begin
                        end_match_next = end_idx + 3'd1;
                    end
                end
                else
                begin
                    end_match_next = (step.data == ipd_pkg::CH_CR) ? 3'd1 : 3'd0;
                end
            end
            else if (!chunked_reg)
            begin
                emit = 1'b1;
            end
            else if (cphase_reg == ipd_pkg::CHUNK_SIZE)
            begin
                if (step.data == ipd_pkg::CH_LF)
                begin
                    cphase_next = ipd_pkg::CHUNK_DATA;
                    skip_next   = 1'b0;
                end
                else if (!ipd_pkg::is_space(step.data))
                begin
                    cremain_next = {cremain_reg[CHUNK_LEN_BITS-5:0],
                                    ipd_pkg::hex_value(step.data)};
                end
            end
            else if (cremain_reg != '0)
            begin
                cremain_next = cremain_reg - 1'b1;
                emit         = 1'b1;
            end
            else if (skip_reg)
            begin
                skip_next    = 1'b0;
                cphase_next  = ipd_pkg::CHUNK_SIZE;
                cremain_next = '0;
            end
            else
            begin
                skip_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_done_reg   <= 1'b0;
            end_match_reg  <= 3'd0;
            word_match_reg <= 3'd0;
            chunked_reg    <= 1'b0;
            cphase_reg     <= ipd_pkg::CHUNK_SIZE;
            cremain_reg    <= '0;
            skip_reg       <= 1'b0;
        end
        else
        begin
            hdr_done_reg   <= hdr_done_next;
            end_match_reg  <= end_match_next;
            word_match_reg <= word_match_next;
            chunked_reg    <= chunked_next;
            cphase_reg     <= cphase_next;
            cremain_reg    <= cremain_next;
            skip_reg       <= skip_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/ipd_http_chunked_deframer.sv */
// each byte passes the input register and then the output register on its way out
// throughput: one byte per cycle unless tx stalls; the outer, header and chunk state update together
// an empty input register takes a new byte while a finished byte waits in the output register
// reset clears every framing and chunk state register and both stage valids
// a restart item returns the framing and chunk state to their reset values and gives no output
// depends on ipd_pkg, ipd_rx_if, ipd_tx_if, ipd_outer, ipd_body
`default_nettype none

module ipd_http_chunked_deframer #(
    parameter int PACKET_LEN_BITS = ipd_pkg::PACKET_LEN_BITS,
    parameter int CHUNK_LEN_BITS  = ipd_pkg::CHUNK_LEN_BITS
) (
    input  wire        clk,
    input  wire        rst_n,
    ipd_rx_if.sink     rx,
    ipd_tx_if.source   tx
);

    logic       in_valid_reg;
    logic       action_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] data_reg;

    logic               advance;
    logic               pass;
    logic               emit;
    ipd_pkg::ipd_step_t outer_step;
    ipd_pkg::ipd_step_t body_step;

    assign advance  = !out_valid_reg || tx.ready;
    assign rx.ready = !in_valid_reg || advance;

    always_comb
    begin
        outer_step.valid   = in_valid_reg && advance;
        outer_step.restart = action_reg;
        outer_step.data    = byte_reg;

        body_step.valid    = pass;
        body_step.restart  = in_valid_reg && advance && action_reg;
        body_step.data     = byte_reg;

        if (advance)
            out_valid_next = in_valid_reg && emit;
        else
            out_valid_next = out_valid_reg;
    end

    ipd_outer #(
        .PACKET_LEN_BITS(PACKET_LEN_BITS)
    ) u_outer (
        .clk  (clk),
        .rst_n(rst_n),
        .step (outer_step),
        .pass (pass)
    );

    ipd_body #(
        .CHUNK_LEN_BITS(CHUNK_LEN_BITS)
    ) u_body (
        .clk  (clk),
        .rst_n(rst_n),
        .step (body_step),
        .emit (emit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx.ready)
                in_valid_reg <= rx.valid;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            action_reg <= rx.action;
            byte_reg   <= rx.byte_in;
        end
        if (advance && in_valid_reg && emit)
            data_reg <= byte_reg;
    end

    assign tx.valid    = out_valid_reg;
    assign tx.data_out = data_reg;

endmodule

`default_nettype wire

/* rtl/ipd_deframer_chk.sv */
// port-level checker for the modem reply deframer, bound to the top level
// depends on ipd_http_chunked_deframer_defines.svh and the top level ports
`default_nettype none

`include "ipd_http_chunked_deframer_defines.svh"

module ipd_deframer_chk (
    input wire       clk,
    input wire       rst_n,
    input wire       rx_valid,
    input wire       rx_ready,
    input wire       rx_action,
    input wire       tx_valid,
    input wire       tx_ready,
    input wire [7:0] tx_data_out
);

    `IPD_ASSERT_HOLD(a_tx_hold, tx_valid, tx_ready, tx_data_out, "output byte changed while stalled")
    `IPD_ASSERT(a_rx_ready_free, !tx_valid |-> rx_ready, "input stalled with empty output")
    `IPD_ASSERT(a_out_from_byte, $rose(tx_valid) |-> $past(rx_valid && rx_ready && !rx_action, 2), "output byte without a data transfer two cycles before")

endmodule

bind ipd_http_chunked_deframer ipd_deframer_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_valid   (rx.valid),
    .rx_ready   (rx.ready),
    .rx_action  (rx.action),
    .tx_valid   (tx.valid),
    .tx_ready   (tx.ready),
    .tx_data_out(tx.data_out)
);

`default_nettype wire

/* verif/ipd_http_chunked_deframer_tb.sv */
// self-checking testbench for ipd_http_chunked_deframer: modem replies in, body bytes out
// a local deframer model predicts every output byte; depends on ipd_pkg, ipd_rx_if, ipd_tx_if
// and the deframer rtl

module ipd_http_chunked_deframer_tb;

    localparam int PERIOD       = 10;
    localparam int RANDOM_ITEMS = 450;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int RUN_LIMIT    = 2_000_000;
    localparam int PKT_BITS     = ipd_pkg::PACKET_LEN_BITS;
    localparam int CHK_BITS     = ipd_pkg::CHUNK_LEN_BITS;

    localparam logic [39:0] MARK_TXT = "+IPD,";
    localparam logic [55:0] WORD_TXT = "chunked";
    localparam logic [PKT_BITS-1:0] PKT_MAX = '1;
    localparam logic [7:0] NO_BYTE = 8'h00;

    typedef struct packed {
        logic       act;
        logic [7:0] b;
        logic       pin;
        logic [7:0] want;
    } item_t;

    typedef enum logic [1:0] {
        SINK_OPEN   = 2'd0,
        SINK_COIN   = 2'd1,
        SINK_EVERY4 = 2'd2,
        SINK_MOSTLY = 2'd3
    } sink_mode_t;

    // restart, marker with a stray plus, length with an ignored digit, header, edge data bytes
    localparam item_t OPENING [20] = '{
        '{1'b1, 8'hFF,             1'b0, NO_BYTE},
        '{1'b0, ipd_pkg::CH_PLUS,  1'b0, NO_BYTE},
        '{1'b0, ipd_pkg::CH_PLUS,  1'b0, NO_BYTE},
        '{1'b0, ipd_pkg::CH_I,     1'b0, NO_BYTE},
        '{1'b0, ipd_pkg::CH_P,     1'b0, NO_BYTE},
        '{1'b0, ipd_pkg::CH_D,     1'b0, NO_BYTE},
        '{1'b0, ipd_pkg::CH_COMMA, 1'b0, NO_BYTE},
        '{1'b0, "7",               1'b0, NO_BYTE},
        '{1'b0, "x",               1'b0, NO_BYTE},
        '{1'b0, "5",               1'b0, NO_BYTE},
        '{1'b0, ipd_pkg::CH_COLON, 1'b0, NO_BYTE},
        '{1'b0, ipd_pkg::CH_CR,    1'b0, NO_BYTE},
        '{1'b0, ipd_pkg::CH_LF,    1'b0, NO_BYTE},
        '{1'b0, ipd_pkg::CH_CR,    1'b0, NO_BYTE},
        '{1'b0, ipd_pkg::CH_LF,    1'b0, NO_BYTE},
        '{1'b0, 8'hFF,             1'b1, 8'hFF},
        '{1'b0, 8'h00,             1'b1, 8'h00},
        '{1'b0, ipd_pkg::CH_PLUS,  1'b1, ipd_pkg::CH_PLUS},
        '{1'b0, "Q",               1'b0, NO_BYTE},
        '{1'b1, 8'h00,             1'b0, NO_BYTE}
    };

    logic clk = 1'b0;
    logic rst_n;

    ipd_rx_if rx_ch ();
    ipd_tx_if tx_ch ();

    ipd_http_chunked_deframer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch)
    );

    // deframer model state
    ipd_pkg::outer_phase_t        outer_st;
    logic [2:0]                   mark_pos;
    logic [PKT_BITS-1:0]          len_sum;
    logic                         len_frozen;
    logic [PKT_BITS-1:0]          pkt_left;
    logic                         hdr_seen;
    logic [2:0]                   crlf_pos;
    logic [2:0]                   word_pos;
    logic                         chunked_on;
    ipd_pkg::chunk_phase_t        chunk_st;
    logic [CHK_BITS-1:0]          chunk_left;
    logic [1:0]                   trail_cnt;

    logic [7:0] payload_q [$];
    item_t      feed_q [$];
    logic [7:0] http_q [$];

    int         mismatch_cnt = 0;
    int         sent_bytes   = 0;
    int         burst_left   = 1;
    logic       cur_pin;
    logic [7:0] cur_want;
    logic       hold_req;
    logic       hold_seen    = 1'b0;
    int         hold_left    = 0;
    int         stall_span   = 0;
    sink_mode_t sink_mode    = SINK_OPEN;
    logic [1:0] tick         = 2'd0;

    always #(PERIOD / 2) clk = ~clk;

    function automatic void clear_deframer();
        outer_st   = ipd_pkg::PH_FIND;
        mark_pos   = '0;
        len_sum    = '0;
        len_frozen = 1'b0;
        pkt_left   = '0;
        hdr_seen   = 1'b0;
        crlf_pos   = '0;
        word_pos   = '0;
        chunked_on = 1'b0;
        chunk_st   = ipd_pkg::CHUNK_SIZE;
        chunk_left = '0;
        trail_cnt  = '0;
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output logic [7:0] payload);
        int unsigned grown;
        logic [3:0]  nib;
        bit          pass;
        payload = NO_BYTE;
        pass    = 1'b0;

        // packet framing
        case (outer_st)
            ipd_pkg::PH_LEN:
            begin
                if (b == ipd_pkg::CH_COLON)
                begin
                    pkt_left   = len_sum;
                    len_sum    = '0;
                    len_frozen = 1'b0;
                    outer_st   = ipd_pkg::PH_DATA;
                end
                else if (!len_frozen && b >= ipd_pkg::CH_0 && b <= ipd_pkg::CH_9)
                begin
                    grown   = int'(len_sum) * 10 + int'(b - ipd_pkg::CH_0);
                    len_sum = (grown > int'(PKT_MAX)) ? PKT_MAX : PKT_BITS'(grown);
                end
                else
                    len_frozen = 1'b1;
            end
            ipd_pkg::PH_DATA:
            begin
                if (pkt_left != '0)
                begin
                    pkt_left--;
                    pass = 1'b1;
                end
                else
                    outer_st = ipd_pkg::PH_FIND;
            end
            default:
            begin
                outer_st = ipd_pkg::PH_FIND;
                if (mark_pos >= ipd_pkg::MARK_LEN)
                    mark_pos = '0;
                if (b == MARK_TXT[8 * (4 - mark_pos) +: 8])
                begin
                    mark_pos++;
                    if (mark_pos == ipd_pkg::MARK_LEN)
                    begin
                        mark_pos = '0;
                        outer_st = ipd_pkg::PH_LEN;
                    end
                end
                else
                    mark_pos = (b == ipd_pkg::CH_PLUS) ? 3'd1 : 3'd0;
            end
        endcase
        if (!pass)
            return 1'b0;

        // http header
        if (!hdr_seen)
        begin
            if (word_pos < ipd_pkg::WORD_LEN)
            begin
                if (b == WORD_TXT[8 * (6 - word_pos) +: 8])
                    word_pos++;
                else
                    word_pos = (b == WORD_TXT[55:48]) ? 3'd1 : 3'd0;
            end
            if (crlf_pos >= ipd_pkg::END_LEN)
                crlf_pos = '0;
            if (b == (crlf_pos[0] ? ipd_pkg::CH_LF : ipd_pkg::CH_CR))
            begin
                crlf_pos++;
                if (crlf_pos == ipd_pkg::END_LEN)
                begin
                    crlf_pos = '0;
                    if (word_pos == ipd_pkg::WORD_LEN)
                    begin
                        chunked_on = 1'b1;
                        chunk_st   = ipd_pkg::CHUNK_SIZE;
                        chunk_left = '0;
                        trail_cnt  = '0;
                    end
                    hdr_seen = 1'b1;
                end
            end
            else
                crlf_pos = (b == ipd_pkg::CH_CR) ? 3'd1 : 3'd0;
            return 1'b0;
        end

        if (!chunked_on)
        begin
            payload = b;
            return 1'b1;
        end

        // chunked body
        if (chunk_st == ipd_pkg::CHUNK_SIZE)
        begin
            if (b == ipd_pkg::CH_LF)
            begin
                chunk_st  = ipd_pkg::CHUNK_DATA;
                trail_cnt = '0;
            end
            else if (!(b == ipd_pkg::CH_SPACE || (b >= ipd_pkg::CH_TAB && b <= ipd_pkg::CH_CR)))
            begin
                if (b >= ipd_pkg::CH_0 && b <= ipd_pkg::CH_9)
                    nib = 4'(b - ipd_pkg::CH_0);
                else if (b >= ipd_pkg::CH_UA && b <= ipd_pkg::CH_UF)
                    nib = 4'(b - ipd_pkg::CH_UA + 8'd10);
                else if (b >= ipd_pkg::CH_LA && b <= ipd_pkg::CH_LF_HEX)
                    nib = 4'(b - ipd_pkg::CH_LA + 8'd10);
                else if (b[7])
                    nib = 4'd0;
                else if (b[7:4] == 4'd0)
                    nib = b[3:0];
                else
                    nib = 4'hF;
                chunk_left = (chunk_left << 4) + CHK_BITS'(nib);
            end
            return 1'b0;
        end
        if (chunk_left != '0)
        begin
            chunk_left--;
            payload = b;
            return 1'b1;
        end
        trail_cnt++;
        if (trail_cnt > 2'd1)
        begin
            trail_cnt  = '0;
            chunk_st   = ipd_pkg::CHUNK_SIZE;
            chunk_left = '0;
        end
        return 1'b0;
    endfunction

    // prediction on every input transfer
    always @(posedge clk)
    begin : take_input
        logic [7:0] byte_out;
        if (rst_n && rx_ch.valid && rx_ch.ready)
        begin
            if (rx_ch.action)
                clear_deframer();
            else if (deframe_byte(rx_ch.byte_in, byte_out))
                payload_q.push_back(cur_pin ? cur_want : byte_out);
        end
    end

    // output check
    always @(posedge clk)
    begin : take_output
        logic [7:0] due;
        if (rst_n && tx_ch.valid && tx_ch.ready)
        begin
            if (payload_q.size() == 0)
            begin
                $error("data_out: expected none, actual %02h", tx_ch.data_out);
                mismatch_cnt++;
            end
            else
            begin
                due = payload_q.pop_front();
                if (tx_ch.data_out !== due)
                begin
                    $error("data_out: expected %02h, actual %02h", due, tx_ch.data_out);
                    mismatch_cnt++;
                end
            end
        end
    end

    // receiver: stall pattern, plus one long hold-off on request
    always @(posedge clk)
    begin
        tick <= tick + 2'd1;
        if (hold_left != 0)
        begin
            tx_ch.ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            tx_ch.ready <= 1'b0;
        end
        else
        begin
            if (stall_span == 0)
            begin
                sink_mode  <= sink_mode_t'($urandom_range(0, 3));
                stall_span <= $urandom_range(8, 60);
            end
            else
                stall_span <= stall_span - 1;
            case (sink_mode)
                SINK_OPEN:   tx_ch.ready <= 1'b1;
                SINK_COIN:   tx_ch.ready <= 1'($urandom_range(0, 1));
                SINK_EVERY4: tx_ch.ready <= (tick == 2'd0);
                default:     tx_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic offer(input item_t it);
        int gap;
        rx_ch.valid   <= 1'b1;
        rx_ch.action  <= it.act;
        rx_ch.byte_in <= it.b;
        cur_pin       <= it.pin;
        cur_want      <= it.want;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        if (!it.act)
            sent_bytes++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0)
            begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic settle();
        rx_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (payload_q.size() != 0);
    endtask

    task automatic to_feed(input logic act, input logic [7:0] b);
        feed_q.push_back(item_t'{act, b, 1'b0, NO_BYTE});
    endtask

    task automatic text_to_feed(input string s);
        for (int i = 0; i < s.len(); i++)
            to_feed(1'b0, s[i]);
    endtask

    task automatic text_to_http(input string s);
        for (int i = 0; i < s.len(); i++)
            http_q.push_back(s[i]);
    endtask

    // bytes biased toward the framing characters
    function automatic logic [7:0] noise_byte();
        logic [7:0] pick;
        case ($urandom_range(0, 7))
            0:       pick = ipd_pkg::CH_PLUS;
            1:       pick = ipd_pkg::CH_I;
            2:       pick = ipd_pkg::CH_P;
            3:       pick = ipd_pkg::CH_D;
            4:       pick = ipd_pkg::CH_COMMA;
            5:       pick = ipd_pkg::CH_COLON;
            default: pick = 8'($urandom_range(0, 255));
        endcase
        return pick;
    endfunction

    task automatic frame_packets();
        int    plen;
        string num;
        while (http_q.size() != 0)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                text_to_feed("+IPD,0:");
                to_feed(1'b0, noise_byte());
            end
            plen = $urandom_range(1, 48);
            if (plen > http_q.size())
                plen = http_q.size();
            num = $sformatf("%0d", plen);
            if ($urandom_range(0, 3) == 0)
                num = {"00", num};
            if ($urandom_range(0, 3) == 0)
                num = {num, ",1,80"};
            text_to_feed({"+IPD,", num, ":"});
            repeat (plen) to_feed(1'b0, http_q.pop_front());
            // byte after the packet is dropped
            to_feed(1'b0, noise_byte());
            repeat ($urandom_range(0, 2)) to_feed(1'b0, noise_byte());
        end
    endtask

    task automatic build_response(input int body_min);
        logic  use_chunks;
        int    sz;
        string sz_txt;
        http_q.delete();
        if ($urandom_range(0, 4) != 0)
            to_feed(1'b1, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 4)) to_feed(1'b0, noise_byte());
        use_chunks = (body_min == 0) && ($urandom_range(0, 1) == 1);

        repeat ($urandom_range(0, 10)) http_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        if (use_chunks)
            text_to_http("Transfer-Encoding: chunked");
        else if ($urandom_range(0, 3) == 0)
            text_to_http("chunke");
        if ($urandom_range(0, 3) == 0)
            text_to_http("\r\n\rX");
        repeat ($urandom_range(0, 10)) http_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        text_to_http("\r\n\r\n");

        if (use_chunks)
        begin
            repeat ($urandom_range(1, 4))
            begin
                sz = $urandom_range(0, 20);
                if ($urandom_range(0, 1) == 0)
                    sz_txt = $sformatf("%0h", sz);
                else
                    sz_txt = $sformatf("%0H", sz);
                case ($urandom_range(0, 9))
                    0: sz_txt = {" ", sz_txt};
                    1: sz_txt = {"\t", sz_txt, " "};
                    2: sz_txt = {"10000000", sz_txt};
                    default: ;
                endcase
                text_to_http(sz_txt);
                // odd size characters
                case ($urandom_range(0, 11))
                    0: http_q.push_back(8'h05);
                    1: http_q.push_back(8'h90);
                    2: http_q.push_back("z");
                    default: ;
                endcase
                text_to_http("\r\n");
                repeat (sz) http_q.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) == 0)
                    repeat (2) http_q.push_back(8'($urandom_range(0, 255)));
                else
                    text_to_http("\r\n");
            end
            text_to_http("0\r\n\r\n");
        end
        else
            repeat (body_min + $urandom_range(0, 30)) http_q.push_back(8'($urandom_range(0, 255)));
        frame_packets();
    endtask

    task automatic build_junk();
        string num;
        to_feed(1'b1, 8'($urandom_range(0, 255)));
        case ($urandom_range(0, 2))
            0:
            begin
                // saturating length
                if ($urandom_range(0, 1) == 0)
                    num = "70000";
                else
                    num = "99999999";
                text_to_feed({"+IPD,", num, ":"});
                text_to_feed("\r\n\r\n");
                repeat ($urandom_range(5, 30)) to_feed(1'b0, 8'($urandom_range(0, 255)));
            end
            1:
                repeat ($urandom_range(5, 30)) to_feed(1'b0, noise_byte());
            default:
            begin
                // cut off inside a packet
                text_to_feed("+IPD,40:");
                repeat ($urandom_range(0, 20)) to_feed(1'b0, noise_byte());
            end
        endcase
    endtask

    initial
    begin : stimulus
        int resp_no;
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.action  = 1'b0;
        rx_ch.byte_in = 8'h00;
        tx_ch.ready   = 1'b0;
        cur_pin       = 1'b0;
        cur_want      = NO_BYTE;
        hold_req      = 1'b0;
        clear_deframer();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(OPENING); i++)
            offer(OPENING[i]);

        sent_bytes = 0;
        resp_no    = 0;
        while (sent_bytes < RANDOM_ITEMS)
        begin
            if (resp_no == 2)
            begin
                hold_req <= ~hold_req;
                build_response(40);
            end
            else if ($urandom_range(0, 5) == 0)
                build_junk();
            else
                build_response(0);
            while (feed_q.size() != 0)
                offer(feed_q.pop_front());
            if (resp_no % 4 == 3)
                settle();
            resp_no++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* ipd_http_chunked_deframer.f */
+incdir+rtl
rtl/ipd_pkg.sv
rtl/ipd_rx_if.sv
rtl/ipd_tx_if.sv
rtl/ipd_outer.sv
rtl/ipd_body.sv
rtl/ipd_http_chunked_deframer.sv
rtl/ipd_deframer_chk.sv
verif/ipd_http_chunked_deframer_tb.sv
